// ----- rtl/core/mtsr_pkg.sv -----
// Shared types, codes and helpers for the multi-type square root block.
// No dependencies; compiled first.
`default_nettype none
package mtsr_pkg;

    // element type codes
    localparam logic [3:0] TYPE_I8  = 4'd0;
    localparam logic [3:0] TYPE_U8  = 4'd1;
    localparam logic [3:0] TYPE_I16 = 4'd2;
    localparam logic [3:0] TYPE_U16 = 4'd3;
    localparam logic [3:0] TYPE_I32 = 4'd4;
    localparam logic [3:0] TYPE_U32 = 4'd5;
    localparam logic [3:0] TYPE_I64 = 4'd6;
    localparam logic [3:0] TYPE_U64 = 4'd7;
    localparam logic [3:0] TYPE_F32 = 4'd8;
    localparam logic [3:0] TYPE_F64 = 4'd9;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NEG   = 2'd1;
    localparam logic [1:0] ST_UNSUP = 2'd2;

    // datapath kind
    localparam logic [1:0] KIND_INT = 2'd0;
    localparam logic [1:0] KIND_F32 = 2'd1;
    localparam logic [1:0] KIND_F64 = 2'd2;

    // root datapath geometry: 56 bit pairs, 4 digits per stage
    localparam int RAD_W           = 112;
    localparam int Q_W             = 56;
    localparam int R_W             = 60;
    localparam int DIGITS_PER_STG  = 4;
    localparam int NUM_ROOT_STAGES = Q_W / DIGITS_PER_STG + 1;
    localparam int NUM_STAGES      = NUM_ROOT_STAGES + 3;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [Q_W-1:0]   q;
        logic [R_W-1:0]   r;
    } root_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               special;
        logic [1:0]         status;
        logic [63:0]        spec_root;
        logic signed [11:0] y;
    } meta_t;

    typedef struct packed {
        meta_t       meta;
        logic [51:0] fm;
        logic [10:0] fe;
        logic [5:0]  lz;
        logic [63:0] ival;
    } p2_t;

    // leading zeros of a 52-bit mantissa field (input nonzero)
    function automatic logic [5:0] lzc52(input logic [51:0] m);
        logic [5:0] n;
        n = 6'd52;
        for (int i = 0; i < 52; i++)
        begin
            if (m[i])
                n = 6'(51 - i);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mtsr_if.sv -----
// Valid/ready channel interfaces for the square root block.
// Depends on nothing; compiled after mtsr_pkg.
`default_nettype none
interface mtsr_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] elem_bits;
    modport source (output valid, output elem_bits, input ready);
    modport sink   (input valid, input elem_bits, output ready);
endinterface

interface mtsr_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] root_bits;
    logic [1:0]  status;
    modport source (output valid, output root_bits, output status, input ready);
    modport sink   (input valid, input root_bits, input status, output ready);
endinterface

interface mtsr_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] element_type;
    modport source (output valid, output element_type, input ready);
    modport sink   (input valid, input element_type, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/multi_type_square_root_top.sv -----
// Top level of the multi-type square root pipeline.
// Depends on mtsr_pkg, mtsr_if (channel interfaces) and mtsr_root_step.
//
// Usage:
//   cfg  : write beat sets element_type (0 i8 .. 7 u64, 8 f32, 9 f64,
//          other codes give status 2). Always ready. Write only while idle.
//   elem : one beat per element, raw bits in the low bits of the type width.
//   root : one beat per element, in order: root_bits (upper bits zero)
//          and status (0 ok, 1 negative input, 2 unsupported type).
// Throughput: one beat per cycle while the root side is ready. The
// pipeline is the 56-digit root recurrence, cut into 14 stages of 4
// digits each, plus decode, normalize, seed and round/pack stages.
// Each stage has its own valid bit and advances when the next one is free
// or moving, so bubbles close up under backpressure and a stalled root
// beat holds while upstream stages keep filling.
// Reset clears all valid bits and sets element_type to i8.
`default_nettype none
module multi_type_square_root_top (
    input  wire             clk,
    input  wire             rst_n,
    mtsr_cfg_if.sink        cfg,
    mtsr_in_if.sink         elem,
    mtsr_out_if.source      root
);
    localparam int NS = mtsr_pkg::NUM_STAGES;
    localparam int NR = mtsr_pkg::NUM_ROOT_STAGES;

    // stage map: 0 decode, 1 normalize, 2..NR+1 root, NS-1 output
    logic [3:0] type_reg;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            type_reg <= mtsr_pkg::TYPE_I8;
        else if (cfg.valid)
            type_reg <= cfg.element_type;
    end

    // per-stage flow control
    logic [NS-1:0] vld_reg;
    logic [NS:0]   rdy;
    logic [NS-1:0] svld;
    logic [NS-1:0] load;

    assign rdy[NS] = root.ready;
    assign svld[0] = elem.valid;

    genvar g;
    generate
        for (g = 0; g < NS; g++)
        begin : g_flow
            assign rdy[g]  = !vld_reg[g] || rdy[g+1];
            assign load[g] = rdy[g] && svld[g];
            if (g > 0)
            begin : g_src
                assign svld[g] = vld_reg[g-1];
            end
        end
    endgenerate

    assign elem.ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (rdy[i])
                    vld_reg[i] <= svld[i];
            end
        end
    end

    // ---- stage 0: capture and decode
    logic [63:0] p1_bits_reg;
    logic [3:0]  p1_type_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            p1_bits_reg <= elem.elem_bits;
            p1_type_reg <= type_reg;
        end
    end

    mtsr_pkg::p2_t p2_next, p2_reg;

    always_comb
    begin
        logic [63:0] b;
        logic [3:0]  t;
        logic [63:0] imask;
        logic        imsb;
        logic        fs;
        logic        emax_hit;
        logic [63:0] fmasked;
        b = p1_bits_reg;
        t = p1_type_reg;
        p2_next = '0;
        unique case (t[2:1])
            2'd0:    begin imask = 64'hFF;        imsb = b[7];  end
            2'd1:    begin imask = 64'hFFFF;      imsb = b[15]; end
            2'd2:    begin imask = 64'hFFFF_FFFF; imsb = b[31]; end
            default: begin imask = '1;            imsb = b[63]; end
        endcase
        if (t == mtsr_pkg::TYPE_F64)
        begin
            fs       = b[63];
            p2_next.fe = b[62:52];
            p2_next.fm = b[51:0];
            emax_hit = (b[62:52] == 11'h7FF);
            fmasked  = b;
        end
        else
        begin
            fs       = b[31];
            p2_next.fe = {3'b000, b[30:23]};
            p2_next.fm = {b[22:0], 29'd0};
            emax_hit = (b[30:23] == 8'hFF);
            fmasked  = {32'd0, b[31:0]};
        end
        p2_next.lz = mtsr_pkg::lzc52(p2_next.fm);
        p2_next.meta.status = mtsr_pkg::ST_OK;
        if (t <= mtsr_pkg::TYPE_U64)
        begin
            p2_next.meta.kind = mtsr_pkg::KIND_INT;
            p2_next.ival = b & imask;
            if (!t[0] && imsb)
            begin
                p2_next.meta.special = 1'b1;
                p2_next.meta.status  = mtsr_pkg::ST_NEG;
            end
        end
        else if (t == mtsr_pkg::TYPE_F32 || t == mtsr_pkg::TYPE_F64)
        begin
            p2_next.meta.kind = (t == mtsr_pkg::TYPE_F64) ? mtsr_pkg::KIND_F64
                                                          : mtsr_pkg::KIND_F32;
            priority if (emax_hit && p2_next.fm != '0)
            begin
                // NaN: return quieted
                p2_next.meta.special = 1'b1;
                p2_next.meta.spec_root = (t == mtsr_pkg::TYPE_F64)
                    ? (b | (64'd1 << 51)) : (fmasked | (64'd1 << 22));
            end
            else if (p2_next.fe == '0 && p2_next.fm == '0)
            begin
                p2_next.meta.special   = 1'b1;
                p2_next.meta.spec_root = fmasked;
            end
            else if (fs)
            begin
                p2_next.meta.special = 1'b1;
                p2_next.meta.status  = mtsr_pkg::ST_NEG;
            end
            else if (emax_hit)
            begin
                p2_next.meta.special   = 1'b1;
                p2_next.meta.spec_root = fmasked;
            end
            else
            begin
                p2_next.meta.special = 1'b0;
            end
        end
        else
        begin
            p2_next.meta.special = 1'b1;
            p2_next.meta.status  = mtsr_pkg::ST_UNSUP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
            p2_reg <= p2_next;
    end

    // ---- stage 1: normalize, halve exponent, build radicand
    mtsr_pkg::root_t root_init;
    mtsr_pkg::meta_t meta_init;

    always_comb
    begin
        logic signed [12:0] bias;
        logic signed [12:0] ex;
        logic signed [12:0] ex2;
        logic [52:0]        mn;
        logic [53:0]        mn2;
        logic [6:0]         sh;
        bias = (p2_reg.meta.kind == mtsr_pkg::KIND_F64) ? 13'sd1023 : 13'sd127;
        sh   = 7'(p2_reg.lz) + 7'd1;
        if (p2_reg.fe == '0)
        begin
            mn = {1'b0, p2_reg.fm} << sh;
            ex = -bias - $signed(13'(p2_reg.lz));
        end
        else
        begin
            mn = {1'b1, p2_reg.fm};
            ex = $signed(13'(p2_reg.fe)) - bias;
        end
        if (ex[0])
        begin
            mn2 = {mn, 1'b0};
            ex2 = ex - 13'sd1;
        end
        else
        begin
            mn2 = {1'b0, mn};
            ex2 = ex;
        end
        meta_init   = p2_reg.meta;
        meta_init.y = ex2[12:1];
        root_init.q = '0;
        root_init.r = '0;
        unique case (p2_reg.meta.kind)
            mtsr_pkg::KIND_F64:
                root_init.rad = mtsr_pkg::RAD_W'(mn2) << 54;
            mtsr_pkg::KIND_F32:
                root_init.rad = mtsr_pkg::RAD_W'(mn2[53:29]) << 25;
            default:
                root_init.rad = mtsr_pkg::RAD_W'(p2_reg.ival);
        endcase
    end

    // ---- root stages: first holds the seed, the rest 4 digits each
    mtsr_pkg::root_t rs_reg [NR];
    mtsr_pkg::meta_t rm_reg [NR];
    mtsr_pkg::root_t rs_step [NR];

    assign rs_step[0] = root_init;

    generate
        for (g = 1; g < NR; g++)
        begin : g_step
            mtsr_root_step u_step (
                .d_in  (rs_reg[g-1]),
                .d_out (rs_step[g])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NR; k++)
        begin
            if (load[k+2])
            begin
                rs_reg[k] <= rs_step[k];
                rm_reg[k] <= (k == 0) ? meta_init : rm_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    // ---- output stage: round float roots to nearest even and pack
    logic [63:0] root_next;
    logic [1:0]  status_next;

    always_comb
    begin
        mtsr_pkg::root_t    s;
        mtsr_pkg::meta_t    m;
        logic [54:0]        mant;
        logic [54:0]        mant_r;
        logic               inc;
        logic signed [11:0] yy;
        logic [11:0]        ex;
        s = rs_reg[NR-1];
        m = rm_reg[NR-1];
        mant   = s.q[mtsr_pkg::Q_W-1:1];
        inc    = s.q[0] && (s.r != '0 || mant[0]);
        mant_r = mant + 55'(inc);
        yy     = m.y;
        root_next   = '0;
        status_next = mtsr_pkg::ST_OK;
        if (m.special)
        begin
            root_next   = m.spec_root;
            status_next = m.status;
        end
        else
        begin
            unique case (m.kind)
                mtsr_pkg::KIND_F64:
                begin
                    if (mant_r[53])
                    begin
                        mant_r = mant_r >> 1;
                        yy     = yy + 12'sd1;
                    end
                    ex = 12'(yy + 12'sd1023);
                    root_next = {1'b0, ex[10:0], mant_r[51:0]};
                end
                mtsr_pkg::KIND_F32:
                begin
                    if (mant_r[24])
                    begin
                        mant_r = mant_r >> 1;
                        yy     = yy + 12'sd1;
                    end
                    ex = 12'(yy + 12'sd127);
                    root_next = {32'd0, 1'b0, ex[7:0], mant_r[22:0]};
                end
                default:
                begin
                    ex = '0;
                    root_next = {32'd0, s.q[31:0]};
                end
            endcase
        end
    end

    logic [63:0] out_root_reg;
    logic [1:0]  out_status_reg;

    always_ff @(posedge clk)
    begin
        if (load[NS-1])
        begin
            out_root_reg   <= root_next;
            out_status_reg <= status_next;
        end
    end

    assign root.valid     = vld_reg[NS-1];
    assign root.root_bits = out_root_reg;
    assign root.status    = out_status_reg;

endmodule
`default_nettype wire

// ----- rtl/core/mtsr_root_step.sv -----
// Four restoring digits of the square root recurrence.
// Depends on mtsr_pkg (root_t).
`default_nettype none
module mtsr_root_step (
    input  var mtsr_pkg::root_t d_in,
    output mtsr_pkg::root_t     d_out
);
    always_comb
    begin
        mtsr_pkg::root_t  s;
        logic [mtsr_pkg::R_W-1:0] t;
        s = d_in;
        for (int k = 0; k < mtsr_pkg::DIGITS_PER_STG; k++)
        begin
            s.r   = {s.r[mtsr_pkg::R_W-3:0], s.rad[mtsr_pkg::RAD_W-1 -: 2]};
            s.rad = {s.rad[mtsr_pkg::RAD_W-3:0], 2'b00};
            t = mtsr_pkg::R_W'({s.q, 2'b01});
            if (s.r >= t)
            begin
                s.r = s.r - t;
                s.q = {s.q[mtsr_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                s.q = {s.q[mtsr_pkg::Q_W-2:0], 1'b0};
            end
        end
        d_out = s;
    end
endmodule
`default_nettype wire

// ----- rtl/core/mtsr_checker.sv -----
// Port-level checks for multi_type_square_root_top, bound to the top level.
// Depends on mtsr_pkg and multi_type_square_root_top.
`default_nettype none
module mtsr_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        cfg_valid,
    input wire        cfg_ready,
    input wire [3:0]  cfg_data,
    input wire        out_valid,
    input wire        out_ready,
    input wire [63:0] out_root,
    input wire [1:0]  out_status
);
    logic [3:0] type_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            type_reg <= mtsr_pkg::TYPE_I8;
        else if (cfg_valid && cfg_ready)
            type_reg <= cfg_data;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_root) && $stable(out_status))
        else $error("root beat changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != mtsr_pkg::ST_OK |-> out_root == 64'd0)
        else $error("error beat carries nonzero root");

    a_unsup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && type_reg > mtsr_pkg::TYPE_F64 |-> out_status == mtsr_pkg::ST_UNSUP)
        else $error("unsupported type without unsupported status");

    a_f32_upper: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && type_reg == mtsr_pkg::TYPE_F32 |-> out_root[63:32] == 32'd0)
        else $error("single result has upper bits set");

endmodule

bind multi_type_square_root_top mtsr_checker u_mtsr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready),
    .cfg_data   (cfg.element_type),
    .out_valid  (root.valid),
    .out_ready  (root.ready),
    .out_root   (root.root_bits),
    .out_status (root.status)
);
`default_nettype wire

// ----- verif/mtsr_sqrt_checker.sv -----
// Checker for the multi-type square root block: predicts each root beat
// from the element beats and the type register, then compares in order.
// Depends on mtsr_pkg and mtsr_if.
`timescale 1ns / 1ps
module mtsr_sqrt_checker (
    input  wire  clk,
    input  wire  rst_n,
    mtsr_cfg_if  cfg,
    mtsr_in_if   elem,
    mtsr_out_if  root,
    output int   fail_count,
    output int   pending_roots
);

    typedef struct packed {
        logic [63:0] bits;
        logic [1:0]  status;
    } root_exp_t;

    logic [3:0] elem_type;
    root_exp_t  expected_roots[$];

    // digit-by-digit floor root over npairs bit pairs of rad
    function automatic logic [63:0] digit_root(input logic [127:0] rad, input int npairs,
                                               output logic inexact);
        logic [63:0] q;
        logic [65:0] r;
        logic [65:0] t;
        q = '0;
        r = '0;
        for (int i = npairs - 1; i >= 0; i--)
        begin
            r = (r << 2) | 66'(rad[2*i +: 2]);
            t = 66'({q, 2'b01});
            if (r >= t)
            begin
                r = r - t;
                q = {q[62:0], 1'b1};
            end
            else
                q = {q[62:0], 1'b0};
        end
        inexact = (r != 0);
        return q;
    endfunction

    function automatic logic [63:0] ieee_root(input logic [63:0] bits, input int mb,
                                              input int eb, output logic [1:0] st);
        int          w;
        int          bias;
        int          ex;
        int          y;
        logic [63:0] emax;
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] mmask;
        logic [63:0] q;
        logic [63:0] mant;
        logic        sticky;
        logic        sgn;
        w = mb + eb + 1;
        sgn = bits[w-1];
        emax = (64'd1 << eb) - 1;
        e = (bits >> mb) & emax;
        mmask = (64'd1 << mb) - 1;
        m = bits & mmask;
        bias = int'(emax >> 1);
        st = mtsr_pkg::ST_OK;
        if (e == emax && m != 0)
            return bits | (64'd1 << (mb - 1));
        if (e == 0 && m == 0)
            return bits;
        if (sgn)
        begin
            st = mtsr_pkg::ST_NEG;
            return '0;
        end
        if (e == emax)
            return bits;
        if (e == 0)
        begin
            ex = 1 - bias;
            while (((m >> mb) & 1) == 0)
            begin
                m = m << 1;
                ex--;
            end
        end
        else
        begin
            m = m | (64'd1 << mb);
            ex = int'(e) - bias;
        end
        if (ex % 2 != 0)
        begin
            m = m << 1;
            ex = ex - 1;
        end
        y = ex / 2;
        q = digit_root(128'(m) << (mb + 2), mb + 2, sticky);
        mant = q >> 1;
        if (q[0] && (sticky || mant[0]))
            mant = mant + 1;
        if ((mant >> (mb + 1)) != 0)
        begin
            mant = mant >> 1;
            y++;
        end
        return (64'(y + bias) << mb) | (mant & mmask);
    endfunction

    function automatic root_exp_t predict_root(input logic [3:0] t, input logic [63:0] bits);
        root_exp_t   res;
        int          w;
        logic [63:0] mask;
        logic [63:0] v;
        logic        unused;
        res = '0;
        if (t <= mtsr_pkg::TYPE_U64)
        begin
            w = 8 << (t >> 1);
            mask = (w == 64) ? '1 : ((64'd1 << w) - 1);
            v = bits & mask;
            if (!t[0] && v[w-1])
                res.status = mtsr_pkg::ST_NEG;
            else
                res.bits = digit_root(128'(v), 32, unused) & mask;
        end
        else if (t == mtsr_pkg::TYPE_F32)
            res.bits = ieee_root({32'd0, bits[31:0]}, 23, 8, res.status) & 64'hFFFF_FFFF;
        else if (t == mtsr_pkg::TYPE_F64)
            res.bits = ieee_root(bits, 52, 11, res.status);
        else
            res.status = mtsr_pkg::ST_UNSUP;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t: root beat error: %s", $realtime, what);
        fail_count++;
    endtask

    assign pending_roots = expected_roots.size();

    always @(posedge clk or negedge rst_n)
    begin
        root_exp_t want;
        if (!rst_n)
        begin
            elem_type <= mtsr_pkg::TYPE_I8;
            fail_count = 0;
            expected_roots.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                elem_type <= cfg.element_type;
            if (elem.valid && elem.ready)
                expected_roots.push_back(predict_root(elem_type, elem.elem_bits));
            if (root.valid && root.ready)
            begin
                if (expected_roots.size() == 0)
                    report_mismatch("unexpected beat");
                else
                begin
                    want = expected_roots.pop_front();
                    if (root.root_bits !== want.bits)
                        report_mismatch($sformatf("root_bits %h, want %h",
                                                  root.root_bits, want.bits));
                    if (root.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  root.status, want.status));
                end
            end
        end
    end

endmodule

// ----- verif/tb_multi_type_square_root_top.sv -----
// Testbench top for multi_type_square_root_top: drives type writes and
// element beats, stalls the root side, and gives the verdict.
// Depends on mtsr_pkg, mtsr_if, mtsr_sqrt_checker and multi_type_square_root_top.
`timescale 1ns / 1ps
module tb_multi_type_square_root_top;

    localparam int DRAIN_CYCLES = 40;       // extra wait after the last expected root
    localparam int STALL_LIMIT  = 5000;     // idle cycles before giving up

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_roots;
    int   idle_cycles;
    logic hold_off;       // long receiver hold-off for the pressure test
    logic stim_done;

    mtsr_cfg_if cfg();
    mtsr_in_if  elem();
    mtsr_out_if root();

    multi_type_square_root_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .elem  (elem),
        .root  (root)
    );

    mtsr_sqrt_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .elem          (elem),
        .root          (root),
        .fail_count    (fail_count),
        .pending_roots (pending_roots)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // drive one element beat, holding it until accepted
    task automatic send_elem(input logic [63:0] bits);
        elem.valid <= 1'b1;
        elem.elem_bits <= bits;
        @(posedge clk);
        while (!elem.ready)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        elem.valid <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(posedge clk);
    endtask

    // wait for idle, then one type register write
    task automatic write_type(input logic [3:0] t);
        elem.valid <= 1'b0;
        @(posedge clk);
        while (pending_roots != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.element_type <= t;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // random element biased toward the interesting corners of type t
    function automatic logic [63:0] rand_elem(input logic [3:0] t);
        logic [63:0] v;
        int          sel;
        v = {$urandom, $urandom};
        sel = $urandom_range(0, 9);
        if (t == mtsr_pkg::TYPE_F32)
        begin
            case (sel)
                0: v[30:23] = 8'hFF;
                1: v[30:23] = 8'h00;
                2: v[31:0] = {v[31], 31'd0};
                3: v[31] = 1'b0;
                4: v[31] = 1'b0;
                default: ;
            endcase
        end
        else if (t == mtsr_pkg::TYPE_F64)
        begin
            case (sel)
                0: v[62:52] = 11'h7FF;
                1: v[62:52] = 11'h000;
                2: v = {v[63], 63'd0};
                3: v[63] = 1'b0;
                4: v[63] = 1'b0;
                default: ;
            endcase
        end
        else if (sel == 0)
            v = v >> $urandom_range(0, 63);
        else if (sel == 1)
            v = '1;
        return v;
    endfunction

    // receiver: random stall pattern, plus the long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            root.ready <= 1'b0;
        else if (hold_off)
            root.ready <= 1'b0;
        else
            root.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end

    // watchdog on accepted beats
    always @(posedge clk)
    begin
        if (!rst_n || (elem.valid && elem.ready) || (root.valid && root.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("multi_type_square_root_top: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [3:0] t;
        int         burst;
        rst_n = 1'b0;
        hold_off = 1'b0;
        stim_done = 1'b0;
        cfg.valid = 1'b0;
        cfg.element_type = mtsr_pkg::TYPE_I8;
        elem.valid = 1'b0;
        elem.elem_bits = '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset type i8 extremes
        send_elem(64'h0);
        send_elem(64'h7F);
        send_elem(64'h80);
        send_elem(64'hFFFF_FFFF_FFFF_FF7F);
        write_type(mtsr_pkg::TYPE_U64);
        send_elem(64'hFFFF_FFFF_FFFF_FFFF);
        send_elem(64'hFFFF_FFFE_0000_0001);
        send_elem(64'hFFFF_FFFE_0000_0000);
        write_type(mtsr_pkg::TYPE_I64);
        send_elem(64'h8000_0000_0000_0000);
        send_elem(64'h7FFF_FFFF_FFFF_FFFF);
        write_type(mtsr_pkg::TYPE_F32);
        send_elem(64'h7FC0_0001);           // NaN
        send_elem(64'h7F80_0001);           // signaling NaN
        send_elem(64'h8000_0000);           // minus zero
        send_elem(64'h7F80_0000);           // plus infinity
        send_elem(64'hFF80_0000);           // minus infinity
        send_elem(64'h0000_0001);           // smallest subnormal
        send_elem(64'hBF80_0000);           // negative
        write_type(mtsr_pkg::TYPE_F64);
        send_elem(64'h7FF0_0000_0000_0001);
        send_elem(64'h8000_0000_0000_0000);
        send_elem(64'h0000_0000_0000_0001);
        send_elem(64'h7FEF_FFFF_FFFF_FFFF);
        write_type(4'd15);                  // unsupported type
        send_elem(64'h1234);
        write_type(4'd10);
        send_elem(64'h0);

        // pressure: receiver held off while the sender keeps offering
        write_type(mtsr_pkg::TYPE_U32);
        fork
            begin
                hold_off <= 1'b1;
                repeat (200)
                    @(posedge clk);
                hold_off <= 1'b0;
            end
            begin
                for (int i = 0; i < 60; i++)
                    send_elem(rand_elem(mtsr_pkg::TYPE_U32));
                elem.valid <= 1'b0;
            end
        join

        // random phases: each picks a type and sends bursts
        for (int phase = 0; phase < 20; phase++)
        begin
            t = (phase < 10) ? 4'(phase) : 4'($urandom_range(0, 15));
            write_type(t);
            for (int n = 0; n < 40; )
            begin
                burst = $urandom_range(1, 12);
                for (int k = 0; k < burst && n < 40; k++, n++)
                    send_elem(rand_elem(t));
                if ($urandom_range(0, 2) != 0)
                    pause_sender();
            end
        end
        elem.valid <= 1'b0;

        @(posedge clk);
        while (pending_roots != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("multi_type_square_root_top: match");
        else
            $display("multi_type_square_root_top: mismatch");
        $finish;
    end

endmodule
